@@ design/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Field widths that do not vary with the value width
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 7;
    localparam int OUT_DATA_W = 8;
    localparam int REM_W      = RADIX_W + 1;

    // Range of accepted bases
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    // Character mapping constants
    localparam logic [DIGIT_W-1:0] CHAR_ZERO   = DIGIT_W'(8'h30);
    localparam logic [DIGIT_W-1:0] CHAR_A      = DIGIT_W'(8'h41);
    localparam logic [DIGIT_W-1:0] CHAR_NONE   = DIGIT_W'(0);
    localparam logic [RADIX_W-1:0] DEC_LIMIT   = RADIX_W'(9);
    localparam logic [DIGIT_W-1:0] DEC_COUNT   = DIGIT_W'(10);

    // Quotient bits resolved per cycle by the divider
    localparam int DIV_STEPS = 8;

    // Classification travelling with each queued request
    typedef struct packed {
        logic               bad;
        logic [RADIX_W-1:0] radix;
    } rdc_cls_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EMIT,
        ST_ERR
    } rdc_state_t;

    // Map a digit value to its ASCII character
    function automatic logic [DIGIT_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        logic [DIGIT_W-1:0] c;
        if (d > DEC_LIMIT)
        begin
            c = CHAR_A + DIGIT_W'(d) - DEC_COUNT;
        end
        else
        begin
            c = CHAR_ZERO + DIGIT_W'(d);
        end
        return c;
    endfunction

endpackage

@@ design/radix_digit_converter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a non-negative integer to ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// Each request carries a value and a base. The block returns one character
// per digit, most significant first, with tlast on the final digit; zero
// gives the single digit '0'. A base outside 2 to 36 gives a single output
// with character 0, tlast set and tuser set. Requests queue in a two-entry
// buffer while the back end works. Each digit is found in the shared
// divider, which resolves eight quotient bits per cycle, and pushed on the
// digit stack; once the value reaches zero the digits are read back from the
// stack and presented one by one.
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [((VALUE_BITS+RADIX_W+7)/8)*8-1:0] s_axis_tdata, // value, radix
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // digit_char
    output logic                  m_axis_tlast,   // last_digit
    output logic                  m_axis_tuser    // bad_radix
);

    localparam int IN_W = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;

    logic                  q_valid;
    logic                  q_ready;
    logic [VALUE_BITS-1:0] q_value;
    rdc_cls_t              q_cls;
    logic [DIGIT_W-1:0]    out_char;

    // Request intake and queue
    rdc_front #(
        .VALUE_BITS (VALUE_BITS),
        .IN_W       (IN_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_value       (q_value),
        .q_cls         (q_cls)
    );

    // Conversion and output
    rdc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_value   (q_value),
        .q_cls     (q_cls),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast),
        .out_bad   (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-DIGIT_W){1'b0}}, out_char};

endmodule

@@ design/rdc_front.sv @@
// ----------------------------------------------------------------------------
// rdc_front
// Accepts conversion requests, checks the base and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rdc_front
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    parameter int IN_W       = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // value, radix
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [VALUE_BITS-1:0] q_value,
    output rdc_cls_t              q_cls
);

    logic [VALUE_BITS-1:0] val_reg [2];
    rdc_cls_t              cls_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  push, pop;
    logic [RADIX_W-1:0]    in_radix;
    rdc_cls_t              in_cls;

    // Unpack and classify the incoming request
    assign in_radix   = s_axis_tdata[VALUE_BITS +: RADIX_W];
    assign in_cls.radix = in_radix;
    assign in_cls.bad   = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);

    // Queue handshakes
    assign s_axis_tready = (count_reg != 2'd2);
    assign q_valid       = (count_reg != 2'd0);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;
    assign q_value       = val_reg[rd_ptr_reg];
    assign q_cls         = cls_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            val_reg[wr_ptr_reg] <= s_axis_tdata[VALUE_BITS-1:0];
            cls_reg[wr_ptr_reg] <= in_cls;
        end
    end

endmodule

@@ design/rdc_back.sv @@
// ----------------------------------------------------------------------------
// rdc_back
// Divides the value repeatedly by the base, stacks the remainders and
// sends them out as characters, most significant digit first.
// ----------------------------------------------------------------------------
module rdc_back
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [VALUE_BITS-1:0] q_value,
    input  rdc_cls_t              q_cls,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIGIT_W-1:0]    out_char,
    output logic                  out_last,
    output logic                  out_bad
);

    localparam int CHUNKS  = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W   = CHUNKS * DIV_STEPS;
    localparam int CHUNK_W = $clog2(CHUNKS + 1);
    localparam int CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W  = $clog2(VALUE_BITS);

    rdc_state_t          state_reg, state_next;
    logic [PAD_W-1:0]    work_reg, work_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic [CHUNK_W-1:0]  chunk_reg, chunk_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]  out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic                out_bad_reg, out_bad_next;
    logic [RADIX_W-1:0]  digit_mem [VALUE_BITS];
    logic [RADIX_W-1:0]  rd_data_reg;
    logic                mem_we;
    logic [CNT_W-1:0]    cnt_dec;
    logic [PAD_W-1:0]    div_work;
    logic [REM_W-1:0]    div_rem;
    logic                last_chunk;
    logic                out_free;

    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign last_chunk = (chunk_reg == CHUNK_W'(CHUNKS - 1));
    assign out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

    // One chunk of restoring division, resolving DIV_STEPS quotient bits
    always_comb
    begin
        div_work = work_reg;
        div_rem  = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            div_rem  = {div_rem[REM_W-2:0], div_work[PAD_W-1]};
            div_work = {div_work[PAD_W-2:0], 1'b0};
            if (div_rem >= {1'b0, radix_reg})
            begin
                div_rem     = div_rem - {1'b0, radix_reg};
                div_work[0] = 1'b1;
            end
        end
    end

    // Sequencer: next state, datapath and output register updates
    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        chunk_next     = chunk_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        q_ready        = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    work_next  = PAD_W'(q_value);
                    radix_next = q_cls.radix;
                    rem_next   = '0;
                    chunk_next = '0;
                    cnt_next   = '0;
                    state_next = q_cls.bad ? ST_ERR : ST_DIV;
                end
            end

            ST_DIV:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                if (last_chunk)
                begin
                    mem_we     = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    rem_next   = '0;
                    chunk_next = '0;
                    if (div_work == '0)
                    begin
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + CHUNK_W'(1);
                end
            end

            ST_READ:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_ascii(rd_data_reg);
                    out_last_next  = (cnt_reg == CNT_W'(1));
                    out_bad_next   = 1'b0;
                    cnt_next       = cnt_dec;
                    state_next     = (cnt_reg == CNT_W'(1)) ? ST_IDLE : ST_READ;
                end
            end

            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_NONE;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunk_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        radix_reg    <= radix_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    // Digit stack: written low digit first, read back from the top
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= div_rem[RADIX_W-1:0];
        end
        rd_data_reg <= digit_mem[cnt_dec[ADDR_W-1:0]];
    end

endmodule
